// ===== src/address_region_table_defines.svh =====
// Assertion macros for the address region table.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef ADDRESS_REGION_TABLE_DEFINES_SVH
`define ADDRESS_REGION_TABLE_DEFINES_SVH

// Same-cycle implication
`define ART_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ART_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/art_pkg.sv =====
package art_pkg;

    // Field widths of the channels
    localparam int ACTION_W   = 2;
    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 49;
    localparam int PROT_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int SLOT_IDX_W = 4;
    localparam int LIVE_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 49;

    typedef logic [ACTION_W-1:0]  action_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Request actions
    localparam action_t ACT_LOOKUP = 2'd0;
    localparam action_t ACT_ENTER  = 2'd1;
    localparam action_t ACT_REMOVE = 2'd2;

    // Result status codes
    localparam status_t STAT_OK      = 3'd0;
    localparam status_t STAT_ZERO    = 3'd1;
    localparam status_t STAT_BADADDR = 3'd2;
    localparam status_t STAT_OVERLAP = 3'd3;
    localparam status_t STAT_FULL    = 3'd4;

    // Configuration register indexes
    localparam cfg_idx_t CFG_WINDOW_LOW  = 1'b0;
    localparam cfg_idx_t CFG_WINDOW_HIGH = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_SCAN,
        S_COMMIT,
        S_DONE
    } state_t;

    // One result item
    typedef struct packed {
        status_t                 status;
        logic                    hit;
        logic [SLOT_IDX_W-1:0]   slot_index;
        logic [ADDR_W-1:0]       found_start;
        logic [SIZE_W-1:0]       found_end;
        logic [PROT_W-1:0]       found_protection;
        logic [LIVE_W-1:0]       live_count;
    } rsp_item_t;

endpackage

// ===== src/art_req_if.sv =====
interface art_req_if;
    import art_pkg::*;

    logic                valid;
    logic                ready;
    action_t             action;
    logic [ADDR_W-1:0]   address;
    logic [SIZE_W-1:0]   region_size;
    logic [SIZE_W-1:0]   end_address;
    logic [PROT_W-1:0]   protection;

    modport source (
        output valid, action, address, region_size, end_address, protection,
        input  ready
    );

    modport sink (
        input  valid, action, address, region_size, end_address, protection,
        output ready
    );
endinterface

// ===== src/art_rsp_if.sv =====
interface art_rsp_if;
    import art_pkg::*;

    logic                    valid;
    logic                    ready;
    status_t                 status;
    logic                    hit;
    logic [SLOT_IDX_W-1:0]   slot_index;
    logic [ADDR_W-1:0]       found_start;
    logic [SIZE_W-1:0]       found_end;
    logic [PROT_W-1:0]       found_protection;
    logic [LIVE_W-1:0]       live_count;

    modport source (
        output valid, status, hit, slot_index, found_start, found_end,
               found_protection, live_count,
        input  ready
    );

    modport sink (
        input  valid, status, hit, slot_index, found_start, found_end,
               found_protection, live_count,
        output ready
    );
endinterface

// ===== src/art_cfg_if.sv =====
interface art_cfg_if;
    import art_pkg::*;

    logic                   valid;
    logic                   ready;
    cfg_idx_t               index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== src/art_slot_mem.sv =====
// Slot store: one write port, one read port, registered read data
module art_slot_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 76
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// ===== src/art_engine.sv =====
// Request sequencer: decodes an item, scans every slot through the slot
// store unless rejected early, then updates the table and builds the result.
module art_engine #(
    parameter int SLOTS      = 16,
    parameter int PAGE_SHIFT = 12,
    parameter int ADDR_BITS  = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    art_req_if.sink                     req,
    input  logic [art_pkg::ADDR_W-1:0]  window_low,
    input  logic [art_pkg::SIZE_W-1:0]  window_high,
    input  logic                        out_free,
    output logic                        res_valid,
    output art_pkg::rsp_item_t          res_item
);
    import art_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int RND_W = SIZE_W + 1;              // rounded end, may carry
    localparam int SP_W  = ADDR_W - PAGE_SHIFT;     // start page
    localparam int EP_W  = SIZE_W - PAGE_SHIFT;     // stored end page
    localparam int RP_W  = RND_W - PAGE_SHIFT;      // request end page
    localparam int ENT_W = SP_W + EP_W + PROT_W;
    localparam int AW    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (AW == ADDR_W) ? '1 : ((ADDR_W'(1) << AW) - ADDR_W'(1));
    localparam logic [RND_W-1:0]  PAGE_MASK = (RND_W'(1) << PAGE_SHIFT) - RND_W'(1);
    localparam bit                AS_CHECK  = (ADDR_BITS < RND_W);
    localparam logic [RND_W-1:0]  AS_LIMIT  = RND_W'(1) << ADDR_BITS;
    localparam logic [CNT_W-1:0]  SLOT_CNT  = CNT_W'(SLOTS);

    state_t                 state_reg, state_next;
    action_t                act_reg;
    logic [SP_W-1:0]        spage_reg;
    logic [RP_W-1:0]        epage_reg;
    logic [PROT_W-1:0]      prot_reg;
    status_t                status_reg;

    logic [CNT_W-1:0]       issue_reg;
    logic                   chk_valid_reg;
    logic [IDX_W-1:0]       chk_idx_reg;

    logic                   found_reg;
    logic [IDX_W-1:0]       found_idx_reg;
    logic [SP_W-1:0]        fnd_s_reg;
    logic [EP_W-1:0]        fnd_e_reg;
    logic [PROT_W-1:0]      fnd_p_reg;
    logic                   overlap_reg;
    logic                   free_ok_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic                   hit_reg;

    logic [SLOTS-1:0]       live_reg;
    logic [CNT_W-1:0]       total_reg;

    // Accept-time decode
    logic [ADDR_W-1:0]      addr_m;
    logic [RND_W-1:0]       size_sum;
    logic [RND_W-1:0]       rm_sum;
    logic [RP_W-1:0]        first_page;
    logic                   accept;

    // Scan compare
    logic                   mem_we;
    logic                   scan_issue;
    logic [IDX_W-1:0]       mem_raddr;
    logic [ENT_W-1:0]       mem_rdata;
    logic [ENT_W-1:0]       mem_wdata;
    logic [SP_W-1:0]        ent_s;
    logic [EP_W-1:0]        ent_e;
    logic [PROT_W-1:0]      ent_p;
    logic [RP_W-1:0]        ent_e_x;
    logic [RP_W-1:0]        ent_s_x;
    logic [RP_W-1:0]        spage_x;
    logic                   chk_live;
    logic                   match;
    logic                   overlaps;
    logic                   take_match;
    logic                   take_free;

    // Enter checks
    logic [ADDR_W-1:0]      start_addr;
    logic [RND_W-1:0]       end_addr;
    logic                   len_zero;
    logic                   win_bad;

    art_slot_mem #(
        .DEPTH (SLOTS),
        .WIDTH (ENT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (free_idx_reg),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Page numbers of the incoming item
    always_comb
    begin
        addr_m   = req.address & ADDR_MASK;
        size_sum = {1'b0, req.region_size} + PAGE_MASK;
        rm_sum   = {1'b0, req.end_address} + PAGE_MASK;
        if (req.action == ACT_REMOVE)
        begin
            first_page = rm_sum[RND_W-1:PAGE_SHIFT];
        end
        else
        begin
            first_page = size_sum[RND_W-1:PAGE_SHIFT];
        end
    end

    // Slot entry compare against the request
    always_comb
    begin
        ent_s    = mem_rdata[ENT_W-1 -: SP_W];
        ent_e    = mem_rdata[PROT_W +: EP_W];
        ent_p    = mem_rdata[PROT_W-1:0];
        ent_e_x  = RP_W'(ent_e);
        ent_s_x  = RP_W'(ent_s);
        spage_x  = RP_W'(spage_reg);
        chk_live = live_reg[chk_idx_reg];
        overlaps = (spage_x < ent_e_x) && (epage_reg > ent_s_x);
        case (act_reg)
            ACT_LOOKUP: match = (spage_x >= ent_s_x) && (spage_x < ent_e_x);
            ACT_REMOVE: match = (spage_reg == ent_s) && (epage_reg == ent_e_x);
            default:    match = 1'b0;
        endcase
        take_match = chk_valid_reg && chk_live && match && !found_reg;
        take_free  = chk_valid_reg && !chk_live && !free_ok_reg;
    end

    // Enter window and size checks
    always_comb
    begin
        start_addr = {spage_reg, {PAGE_SHIFT{1'b0}}};
        end_addr   = {epage_reg, {PAGE_SHIFT{1'b0}}};
        len_zero   = (epage_reg == spage_x);
        win_bad    = (start_addr < window_low)
                  || (end_addr > RND_W'(window_high))
                  || (AS_CHECK && (end_addr > AS_LIMIT));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                unique case (act_reg)
                    ACT_LOOKUP, ACT_REMOVE: state_next = S_SCAN;
                    ACT_ENTER:              state_next = S_CHECK;
                    default:                state_next = S_DONE;
                endcase
            end
            S_CHECK:
            begin
                if (len_zero || win_bad)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if ((issue_reg == SLOT_CNT) && !chk_valid_reg)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        req.ready  = (state_reg == S_IDLE);
        accept     = req.valid && (state_reg == S_IDLE);
        scan_issue = (state_reg == S_SCAN) && (issue_reg < SLOT_CNT);
        mem_raddr  = issue_reg[IDX_W-1:0];
        mem_we     = (state_reg == S_COMMIT) && (act_reg == ACT_ENTER)
                  && !overlap_reg && free_ok_reg;
        mem_wdata  = {spage_reg, epage_reg[EP_W-1:0], prot_reg};
        res_valid  = (state_reg == S_DONE) && out_free;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            overlap_reg   <= 1'b0;
            free_ok_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            live_reg      <= '0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                issue_reg     <= '0;
                chk_valid_reg <= 1'b0;
                found_reg     <= 1'b0;
                overlap_reg   <= 1'b0;
                free_ok_reg   <= 1'b0;
                hit_reg       <= 1'b0;
            end
            if (state_reg == S_SCAN)
            begin
                chk_valid_reg <= scan_issue;
                if (scan_issue)
                begin
                    issue_reg <= issue_reg + CNT_W'(1);
                end
                if (take_match)
                begin
                    found_reg <= 1'b1;
                end
                if (chk_valid_reg && chk_live && overlaps)
                begin
                    overlap_reg <= 1'b1;
                end
                if (take_free)
                begin
                    free_ok_reg <= 1'b1;
                end
            end
            // Table update
            if (state_reg == S_COMMIT)
            begin
                hit_reg <= (act_reg == ACT_LOOKUP) && found_reg;
                if (mem_we)
                begin
                    live_reg[free_idx_reg] <= 1'b1;
                    total_reg              <= total_reg + CNT_W'(1);
                end
                if ((act_reg == ACT_REMOVE) && found_reg)
                begin
                    live_reg[found_idx_reg] <= 1'b0;
                    if (total_reg != '0)
                    begin
                        total_reg <= total_reg - CNT_W'(1);
                    end
                end
            end
        end
    end

    // Request and scan payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= req.action;
            spage_reg <= addr_m[ADDR_W-1:PAGE_SHIFT];
            epage_reg <= first_page;
            prot_reg  <= req.protection;
        end
        if (state_reg == S_PREP)
        begin
            status_reg <= STAT_BADADDR;
            if (act_reg == ACT_ENTER)
            begin
                epage_reg <= spage_x + epage_reg;
            end
        end
        if (state_reg == S_CHECK)
        begin
            status_reg <= len_zero ? STAT_ZERO : STAT_BADADDR;
        end
        if (state_reg == S_SCAN)
        begin
            chk_idx_reg <= mem_raddr;
            if (take_match)
            begin
                found_idx_reg <= chk_idx_reg;
                fnd_s_reg     <= ent_s;
                fnd_e_reg     <= ent_e;
                fnd_p_reg     <= ent_p;
            end
            if (take_free)
            begin
                free_idx_reg <= chk_idx_reg;
            end
        end
        // Final status
        if (state_reg == S_COMMIT)
        begin
            unique case (act_reg)
                ACT_ENTER:
                begin
                    if (overlap_reg)
                    begin
                        status_reg <= STAT_OVERLAP;
                    end
                    else if (free_ok_reg)
                    begin
                        status_reg <= STAT_OK;
                    end
                    else
                    begin
                        status_reg <= STAT_FULL;
                    end
                end
                ACT_LOOKUP, ACT_REMOVE:
                begin
                    status_reg <= found_reg ? STAT_OK : STAT_BADADDR;
                end
                default:
                begin
                    status_reg <= STAT_BADADDR;
                end
            endcase
        end
    end

    // Result item
    always_comb
    begin
        res_item.status = status_reg;
        res_item.hit    = hit_reg;
        if (status_reg != STAT_OK)
        begin
            res_item.slot_index = '0;
        end
        else if (act_reg == ACT_ENTER)
        begin
            res_item.slot_index = SLOT_IDX_W'(free_idx_reg);
        end
        else
        begin
            res_item.slot_index = SLOT_IDX_W'(found_idx_reg);
        end
        if (hit_reg)
        begin
            res_item.found_start      = {fnd_s_reg, {PAGE_SHIFT{1'b0}}};
            res_item.found_end        = {fnd_e_reg, {PAGE_SHIFT{1'b0}}};
            res_item.found_protection = fnd_p_reg;
        end
        else
        begin
            res_item.found_start      = '0;
            res_item.found_end        = '0;
            res_item.found_protection = '0;
        end
        res_item.live_count = LIVE_W'(total_reg);
    end
endmodule

// ===== src/address_region_table.sv =====
// Channel | Dir | Payload
// req     | in  | action, address, region_size, end_address, protection
// rsp     | out | status, hit, slot_index, found_start/end/protection, live_count
// cfg     | in  | index (0 window_low, 1 window_high), data; always ready
//
// One item at a time: lookup and remove scan every slot, enter checks first;
// the full scan reads one slot from the slot store each cycle.
// A bad action, zero size or window failure finishes without a scan.
// Reset empties the table and sets the window to [0, 2^48); no clearing pass.
// The result sits in an output register; a stalled rsp holds only the
// sequencer's last step, and req may be taken while the result waits.
`include "address_region_table_defines.svh"

module address_region_table #(
    parameter int SLOTS      = 16,
    parameter int PAGE_SHIFT = 12,
    parameter int ADDR_BITS  = 48
) (
    input  logic       clk,
    input  logic       rst_n,
    art_req_if.sink    req,
    art_rsp_if.source  rsp,
    art_cfg_if.sink    cfg
);
    import art_pkg::*;

    logic [ADDR_W-1:0]  window_low_reg;
    logic [SIZE_W-1:0]  window_high_reg;
    rsp_item_t          rsp_item_reg;
    logic               rsp_valid_reg;
    logic               out_free;
    logic               res_valid;
    rsp_item_t          res_item;

    art_engine #(
        .SLOTS      (SLOTS),
        .PAGE_SHIFT (PAGE_SHIFT),
        .ADDR_BITS  (ADDR_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .window_low  (window_low_reg),
        .window_high (window_high_reg),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res_item    (res_item)
    );

    // Window registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg  <= '0;
            window_high_reg <= SIZE_W'(1) << ADDR_W;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_WINDOW_LOW:  window_low_reg  <= cfg.data[ADDR_W-1:0];
                CFG_WINDOW_HIGH: window_high_reg <= cfg.data[SIZE_W-1:0];
                default:         window_low_reg  <= window_low_reg;
            endcase
        end
    end

    // Output register
    assign out_free = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_item_reg <= res_item;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = rsp_item_reg.status;
    assign rsp.hit              = rsp_item_reg.hit;
    assign rsp.slot_index       = rsp_item_reg.slot_index;
    assign rsp.found_start      = rsp_item_reg.found_start;
    assign rsp.found_end        = rsp_item_reg.found_end;
    assign rsp.found_protection = rsp_item_reg.found_protection;
    assign rsp.live_count       = rsp_item_reg.live_count;

    // Checks
    `ART_ASSERT_IMPL(a_hit_region, rsp.valid && rsp.hit,
        (rsp.status == STAT_OK) && (rsp.found_end > SIZE_W'(rsp.found_start)),
        "lookup hit without a nonempty region")
    `ART_ASSERT_IMPL(a_fail_clean, rsp.valid && (rsp.status != STAT_OK),
        (rsp.slot_index == '0) && !rsp.hit,
        "failed item reports a slot or a hit")
    `ART_ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready,
        "second item taken while one is in work")
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import art_pkg::*;

    localparam int          TBL_SLOTS   = 16;
    localparam int          PG_SHIFT    = 12;
    localparam int          PAGE        = 1 << PG_SHIFT;
    localparam logic [63:0] PG_MASK     = 64'(PAGE - 1);
    localparam logic [47:0] ADDR_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [48:0] ADDR_SPAN   = 49'h1_0000_0000_0000;
    localparam action_t     ACT_UNKNOWN = 2'd3;
    localparam int          IDLE_LIMIT  = 3000;
    localparam int          TAIL_CYCLES = TBL_SLOTS + 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    art_req_if req_ch ();
    art_rsp_if rsp_ch ();
    art_cfg_if cfg_ch ();

    address_region_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the window and the region table
    logic [47:0] win_low;
    logic [48:0] win_high;
    logic        slot_live     [TBL_SLOTS];
    logic [35:0] slot_start_pg [TBL_SLOTS];
    logic [36:0] slot_end_pg   [TBL_SLOTS];
    logic [2:0]  slot_rights   [TBL_SLOTS];
    logic [4:0]  live_total;

    rsp_item_t   expected_results [$];
    int          error_count   = 0;
    int          stall_cycles  = 0;
    int          send_idle_pct = 36;
    int          recv_idle_pct = 76;
    logic [47:0] pool_base     = '0;

    always #5 clk = ~clk;

    function automatic logic [63:0] region_lo(input int i);
        return {16'd0, slot_start_pg[i], 12'd0};
    endfunction

    function automatic logic [63:0] region_hi(input int i);
        return {15'd0, slot_end_pg[i], 12'd0};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Byte count in 0 .. 2^48
    function automatic logic [48:0] rand_span();
        logic [63:0] v;
        v = rand64();
        if ($urandom_range(0, 15) == 0)
            return ADDR_SPAN;
        return {1'b0, v[47:0]};
    endfunction

    // Expected result of one request; updates the shadow table
    function automatic rsp_item_t table_predict(input action_t act, input logic [47:0] addr,
            input logic [48:0] size, input logic [48:0] end_in, input logic [2:0] prot);
        rsp_item_t   r;
        logic [63:0] start_a, len_a, end_a, lo, hi;
        int          slot;
        bit          overlap;
        r        = '0;
        r.status = STAT_BADADDR;
        slot     = -1;
        overlap  = 1'b0;
        start_a  = {16'd0, addr} & ~PG_MASK;
        case (act)
            ACT_LOOKUP:
            begin
                // scan downward so the lowest hit wins
                for (int i = TBL_SLOTS - 1; i >= 0; i--)
                    if (slot_live[i] && {16'd0, addr} >= region_lo(i)
                            && {16'd0, addr} < region_hi(i))
                        slot = i;
                if (slot >= 0)
                begin
                    lo                 = region_lo(slot);
                    hi                 = region_hi(slot);
                    r.status           = STAT_OK;
                    r.hit              = 1'b1;
                    r.slot_index       = slot[3:0];
                    r.found_start      = lo[47:0];
                    r.found_end        = hi[48:0];
                    r.found_protection = slot_rights[slot];
                end
            end
            ACT_ENTER:
            begin
                len_a = ({15'd0, size} + PG_MASK) & ~PG_MASK;
                end_a = start_a + len_a;
                if (len_a == 0)
                    r.status = STAT_ZERO;
                else if (start_a < {16'd0, win_low} || end_a > {15'd0, win_high}
                        || end_a > {15'd0, ADDR_SPAN})
                    r.status = STAT_BADADDR;
                else
                begin
                    for (int i = TBL_SLOTS - 1; i >= 0; i--)
                    begin
                        if (slot_live[i] && start_a < region_hi(i) && end_a > region_lo(i))
                            overlap = 1'b1;
                        if (!slot_live[i])
                            slot = i;
                    end
                    if (overlap)
                        r.status = STAT_OVERLAP;
                    else if (slot < 0)
                        r.status = STAT_FULL;
                    else
                    begin
                        slot_start_pg[slot] = start_a[47:PG_SHIFT];
                        slot_end_pg[slot]   = end_a[48:PG_SHIFT];
                        slot_rights[slot]   = prot;
                        slot_live[slot]     = 1'b1;
                        live_total++;
                        r.status     = STAT_OK;
                        r.slot_index = slot[3:0];
                    end
                end
            end
            ACT_REMOVE:
            begin
                end_a = ({15'd0, end_in} + PG_MASK) & ~PG_MASK;
                for (int i = TBL_SLOTS - 1; i >= 0; i--)
                    if (slot_live[i] && region_lo(i) == start_a && region_hi(i) == end_a)
                        slot = i;
                if (slot >= 0)
                begin
                    slot_live[slot] = 1'b0;
                    if (live_total != 0)
                        live_total--;
                    r.status     = STAT_OK;
                    r.slot_index = slot[3:0];
                end
            end
            default:
                ; // unknown action: nothing changes
        endcase
        r.live_count = live_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
            input logic [63:0] want);
        error_count++;
        if (error_count <= 200)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
            input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Send one request item, with random idle before it
    task automatic send_request(input action_t act, input logic [47:0] addr,
            input logic [48:0] size, input logic [48:0] end_in, input logic [2:0] prot);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.address     <= addr;
        req_ch.region_size <= size;
        req_ch.end_address <= end_in;
        req_ch.protection  <= prot;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_results.push_back(table_predict(act, addr, size, end_in, prot));
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input cfg_idx_t idx, input logic [48:0] value);
        drain_results();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == CFG_WINDOW_LOW)
            win_low = value[47:0];
        else
            win_high = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-aimed requests around pool_base and the live regions
    task automatic send_random_request();
        logic [63:0] rnd, lo, hi;
        logic [47:0] addr;
        logic [48:0] size, end_in;
        logic [2:0]  prot;
        action_t     act;
        int          live_idx [$];
        int          pick, k;
        rnd    = rand64();
        addr   = pool_base + 48'(($urandom_range(0, 47) << PG_SHIFT) + $urandom_range(0, PAGE - 1));
        size   = rand_span();
        end_in = rand_span();
        prot   = 3'($urandom_range(0, 7));
        lo     = '0;
        hi     = '0;
        pick   = -1;
        for (int i = 0; i < TBL_SLOTS; i++)
            if (slot_live[i])
                live_idx.push_back(i);
        if (live_idx.size() != 0)
        begin
            pick = live_idx[$urandom_range(0, live_idx.size() - 1)];
            lo   = region_lo(pick);
            hi   = region_hi(pick);
        end
        k = $urandom_range(0, 99);
        if (k < 40)
        begin
            act = ACT_ENTER;
            case ($urandom_range(0, 9))
                0: size = '0;
                1: addr = rnd[47:0];
                2:
                begin
                    // right behind a live region
                    if (pick >= 0)
                        addr = hi[47:0];
                    size = 49'($urandom_range(1, 4 * PAGE));
                end
                default: size = 49'($urandom_range(1, 6 * PAGE));
            endcase
        end
        else if (k < 65)
        begin
            act = ACT_REMOVE;
            if (pick >= 0 && $urandom_range(0, 4) != 0)
            begin
                // sub-page offsets that round back onto the region bounds
                addr   = lo[47:0] + 48'($urandom_range(0, PAGE - 1));
                end_in = hi[48:0] - 49'($urandom_range(0, PAGE - 1));
            end
            else
                end_in = {1'b0, addr} + 49'($urandom_range(1, 6 * PAGE));
        end
        else if (k < 95)
        begin
            act = ACT_LOOKUP;
            case ($urandom_range(0, 5))
                0: addr = rnd[47:0];
                1: if (pick >= 0) addr = hi[47:0];
                2, 3: if (pick >= 0) addr = 48'(lo + (rand64() % (hi - lo)));
                default: ;
            endcase
        end
        else
            act = ACT_UNKNOWN;
        send_request(act, addr, size, end_in, prot);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_request();
    endtask

    task automatic test_empty_table();
        send_request(ACT_LOOKUP, 48'h0, 49'h0, 49'h0, 3'd0);
        send_request(ACT_LOOKUP, ADDR_MAX, ADDR_SPAN, ADDR_SPAN, 3'd7);
        send_request(ACT_REMOVE, 48'h0, 49'h0, 49'(PAGE), 3'd0);
        send_request(ACT_UNKNOWN, ADDR_MAX, ADDR_SPAN, ADDR_SPAN, 3'd7);
        send_request(ACT_ENTER, 48'h1234, 49'h0, ADDR_SPAN, 3'd7);
    endtask

    task automatic test_region_bounds();
        // first page, last page, and bounds that run off the address space
        send_request(ACT_ENTER, 48'h0, 49'h1, 49'h0, 3'd1);
        send_request(ACT_ENTER, 48'hFFF, 49'(PAGE), 49'h0, 3'd2);
        send_request(ACT_ENTER, ADDR_MAX, 49'h1, 49'h0, 3'd7);
        send_request(ACT_ENTER, ADDR_MAX - 48'hFFF, 49'(PAGE + 1), 49'h0, 3'd3);
        send_request(ACT_ENTER, 48'h1000, ADDR_SPAN, 49'h0, 3'd3);
        send_request(ACT_ENTER, 48'h1000, 49'h10_0000, 49'h0, 3'd6);
        // lookups at region edges
        send_request(ACT_LOOKUP, 48'h10_0FFF, 49'h0, 49'h0, 3'd0);
        send_request(ACT_LOOKUP, 48'h10_1000, 49'h0, 49'h0, 3'd0);
        send_request(ACT_LOOKUP, ADDR_MAX, 49'h0, 49'h0, 3'd0);
        send_request(ACT_LOOKUP, 48'hFFF, 49'h0, 49'h0, 3'd0);
        // remove with unaligned end, then again when gone
        send_request(ACT_REMOVE, 48'h1000, 49'h0, 49'h10_0FFF, 3'd0);
        send_request(ACT_REMOVE, 48'h1000, 49'h0, 49'h10_0FFF, 3'd0);
        send_request(ACT_REMOVE, ADDR_MAX - 48'hFFF, 49'h0, ADDR_SPAN, 3'd0);
        send_request(ACT_ENTER, 48'h5000, 49'h1FFF, 49'h0, 3'd4);
        send_request(ACT_REMOVE, 48'h5000, 49'h0, 49'h6000, 3'd0);
        send_request(ACT_REMOVE, 48'h5FFF, 49'h0, 49'h6001, 3'd0);
        // whole address space
        send_request(ACT_ENTER, 48'h0, ADDR_SPAN, 49'h0, 3'd5);
        send_request(ACT_REMOVE, 48'h0, 49'h0, 49'h1, 3'd0);
        send_request(ACT_ENTER, 48'h0, ADDR_SPAN, 49'h0, 3'd5);
        send_request(ACT_LOOKUP, 48'h8000_0000_0000, 49'h0, 49'h0, 3'd0);
        send_request(ACT_REMOVE, 48'h0, 49'h0, ADDR_SPAN, 3'd0);
    endtask

    task automatic test_table_full();
        logic [47:0] base;
        base = 48'h0100_0000;
        for (int i = 0; i < TBL_SLOTS; i++)
            send_request(ACT_ENTER, base + 48'(i * 2 * PAGE), 49'(PAGE), 49'h0, 3'(i));
        // full table; overlap and zero size are checked first
        send_request(ACT_ENTER, 48'h0200_0000, 49'(PAGE), 49'h0, 3'd7);
        send_request(ACT_ENTER, base, 49'(PAGE), 49'h0, 3'd7);
        send_request(ACT_ENTER, 48'h0200_0000, 49'h0, 49'h0, 3'd7);
        send_request(ACT_LOOKUP, base + 48'(PAGE), 49'h0, 49'h0, 3'd0);
        send_request(ACT_LOOKUP, base + 48'((2 * TBL_SLOTS - 1) * PAGE - 1), 49'h0, 49'h0, 3'd0);
        for (int i = TBL_SLOTS - 1; i >= 0; i--)
            send_request(ACT_REMOVE, base + 48'(i * 2 * PAGE), 49'h0,
                         49'(base) + 49'((i * 2 + 1) * PAGE), 3'd0);
    endtask

    task automatic test_narrow_window();
        logic [47:0] base;
        base = 48'h0000_4000_0000;
        // low bound off the page grid, so the first page is rejected
        write_window(CFG_WINDOW_LOW, {1'b0, base + 48'h800});
        write_window(CFG_WINDOW_HIGH, {1'b0, base} + 49'(40 * PAGE));
        pool_base = base - 48'(8 * PAGE);
        test_random_traffic(250);
    endtask

    task automatic test_inverted_window();
        write_window(CFG_WINDOW_LOW, {1'b0, ADDR_MAX});
        write_window(CFG_WINDOW_HIGH, 49'h0);
        test_random_traffic(15);
        // equal bounds are empty as well
        write_window(CFG_WINDOW_HIGH, {1'b0, ADDR_MAX});
        test_random_traffic(15);
    endtask

    task automatic test_top_of_space();
        write_window(CFG_WINDOW_LOW, 49'h0);
        write_window(CFG_WINDOW_HIGH, ADDR_SPAN);
        pool_base = 48'(ADDR_SPAN - 49'(40 * PAGE));
        test_random_traffic(260);
    endtask

    // Result ready with random stalls
    initial rsp_ch.ready = 1'b0;
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing pending", 64'(rsp_ch.status), 64'h0);
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 64'(rsp_ch.status), 64'(want.status));
                check_field("hit", 64'(rsp_ch.hit), 64'(want.hit));
                check_field("slot_index", 64'(rsp_ch.slot_index), 64'(want.slot_index));
                check_field("found_start", 64'(rsp_ch.found_start), 64'(want.found_start));
                check_field("found_end", 64'(rsp_ch.found_end), 64'(want.found_end));
                check_field("found_protection", 64'(rsp_ch.found_protection),
                            64'(want.found_protection));
                check_field("live_count", 64'(rsp_ch.live_count), 64'(want.live_count));
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_LOOKUP;
        req_ch.address     = '0;
        req_ch.region_size = '0;
        req_ch.end_address = '0;
        req_ch.protection  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_WINDOW_LOW;
        cfg_ch.data        = '0;
        win_low            = '0;
        win_high           = ADDR_SPAN;
        live_total         = '0;
        for (int i = 0; i < TBL_SLOTS; i++)
        begin
            slot_live[i]     = 1'b0;
            slot_start_pg[i] = '0;
            slot_end_pg[i]   = '0;
            slot_rights[i]   = '0;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender idles lightly, receiver heavily
        test_empty_table();
        test_region_bounds();
        test_table_full();
        pool_base = 48'h0;
        test_random_traffic(260);

        // the other way round
        send_idle_pct = 76;
        recv_idle_pct = 36;
        test_narrow_window();
        test_inverted_window();

        // full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_top_of_space();

        drain_results();
        if (expected_results.size() != 0)
            report_mismatch("results never arrived", 64'(expected_results.size()), 64'h0);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/art_pkg.sv
src/art_req_if.sv
src/art_rsp_if.sv
src/art_cfg_if.sv
src/art_slot_mem.sv
src/art_engine.sv
src/address_region_table.sv
dv/tb_top.sv
